// File: rtl/rtc_pkg.sv
// Shared widths, types and the multiply micro-program for the ray/triangle
// closest-hit block. No dependencies.
package rtc_pkg;

  localparam int CW    = 32;      // coordinate width, Q15.16
  localparam int DW    = 18;      // direction width, Q1.16
  localparam int EW    = CW + 1;  // edge and origin offset width
  localparam int HW    = 52;      // d x e2
  localparam int QW    = 67;      // s x e1
  localparam int PW    = 87;      // det, un, vn
  localparam int TW    = 102;     // tn
  localparam int AW    = 68;      // wide multiplier operand
  localparam int DIG   = 11;      // digit of the narrow operand
  localparam int NDIG  = 3;
  localparam int BW    = DIG * NDIG;
  localparam int PRODW = AW + DIG + 1;
  localparam int ACCW  = 104;
  localparam int OUT_W = 32;
  localparam int RW    = PW + 1;  // divider remainder
  localparam int NUM_OPS = 24;
  localparam int UPC_W   = 5;
  localparam int CFG_IDX_W = 8;
  localparam int TDATA_IN_W  = 320;
  localparam int TDATA_OUT_W = 64;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int PARALLEL_EPS_DEF = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 8'd6;

  // one triangle after the front end: edges, origin offset and tags
  typedef struct packed {
    logic [2:0][EW-1:0] e1;
    logic [2:0][EW-1:0] e2;
    logic [2:0][EW-1:0] s;
    logic [OUT_W-1:0]   feature;
    logic               ok;
    logic               last;
  } tri_t;

  typedef enum logic [1:0] {A_E2, A_S, A_H, A_Q} asrc_t;
  typedef enum logic [1:0] {B_D, B_E1, B_S, B_E2} bsrc_t;
  typedef enum logic [2:0] {
    DST_NONE, DST_H, DST_Q, DST_DET, DST_UN, DST_VN, DST_TN
  } dst_t;

  typedef struct packed {
    asrc_t       asel;
    logic [1:0]  aidx;
    bsrc_t       bsel;
    logic [1:0]  bidx;
    logic        neg;
    logic        first;
    dst_t        dst;
    logic [1:0]  didx;
  } op_t;

  function automatic op_t mk(asrc_t as, logic [1:0] ai, bsrc_t bs, logic [1:0] bi,
                             logic ng, logic fs, dst_t ds, logic [1:0] di);
    op_t o;
    o.asel  = as;
    o.aidx  = ai;
    o.bsel  = bs;
    o.bidx  = bi;
    o.neg   = ng;
    o.first = fs;
    o.dst   = ds;
    o.didx  = di;
    return o;
  endfunction

  // h = d x e2, q = s x e1, then det = h.e1, un = h.s, vn = q.d, tn = q.e2
  function automatic op_t uop(logic [UPC_W-1:0] idx);
    op_t o;
    case (idx)
      5'd0:  o = mk(A_E2, 2'd2, B_D,  2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd1:  o = mk(A_E2, 2'd1, B_D,  2'd2, 1'b1, 1'b0, DST_H,    2'd0);
      5'd2:  o = mk(A_E2, 2'd0, B_D,  2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd3:  o = mk(A_E2, 2'd2, B_D,  2'd0, 1'b1, 1'b0, DST_H,    2'd1);
      5'd4:  o = mk(A_E2, 2'd1, B_D,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd5:  o = mk(A_E2, 2'd0, B_D,  2'd1, 1'b1, 1'b0, DST_H,    2'd2);
      5'd6:  o = mk(A_S,  2'd1, B_E1, 2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd7:  o = mk(A_S,  2'd2, B_E1, 2'd1, 1'b1, 1'b0, DST_Q,    2'd0);
      5'd8:  o = mk(A_S,  2'd2, B_E1, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd9:  o = mk(A_S,  2'd0, B_E1, 2'd2, 1'b1, 1'b0, DST_Q,    2'd1);
      5'd10: o = mk(A_S,  2'd0, B_E1, 2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd11: o = mk(A_S,  2'd1, B_E1, 2'd0, 1'b1, 1'b0, DST_Q,    2'd2);
      5'd12: o = mk(A_H,  2'd0, B_E1, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd13: o = mk(A_H,  2'd1, B_E1, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd14: o = mk(A_H,  2'd2, B_E1, 2'd2, 1'b0, 1'b0, DST_DET,  2'd0);
      5'd15: o = mk(A_H,  2'd0, B_S,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd16: o = mk(A_H,  2'd1, B_S,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd17: o = mk(A_H,  2'd2, B_S,  2'd2, 1'b0, 1'b0, DST_UN,   2'd0);
      5'd18: o = mk(A_Q,  2'd0, B_D,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd19: o = mk(A_Q,  2'd1, B_D,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd20: o = mk(A_Q,  2'd2, B_D,  2'd2, 1'b0, 1'b0, DST_VN,   2'd0);
      5'd21: o = mk(A_Q,  2'd0, B_E2, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd22: o = mk(A_Q,  2'd1, B_E2, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd23: o = mk(A_Q,  2'd2, B_E2, 2'd2, 1'b0, 1'b0, DST_TN,   2'd0);
      default: o = mk(A_E2, 2'd0, B_D, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
    endcase
    return o;
  endfunction

endpackage

// File: rtl/rtc_front.sv
// Front end: accepts triangle items and forms the edges and origin offset.
// Depends on rtc_pkg.
module rtc_front (
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rtc_pkg::TDATA_IN_W-1:0]         in_data,
  input  logic                                   in_ok,
  input  logic                                   in_last,
  input  logic signed [rtc_pkg::CW-1:0]          origin [3],
  input  logic                                   q_full,
  output logic                                   push,
  output rtc_pkg::tri_t                          wdata
);

  localparam int CW = rtc_pkg::CW;
  localparam int EW = rtc_pkg::EW;

  logic signed [EW-1:0] va [3];
  logic signed [EW-1:0] vb [3];
  logic signed [EW-1:0] vc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = EW'($signed(in_data[i*CW +: CW]));
      vb[i] = EW'($signed(in_data[(3+i)*CW +: CW]));
      vc[i] = EW'($signed(in_data[(6+i)*CW +: CW]));
      wdata.e1[i] = vb[i] - va[i];
      wdata.e2[i] = vc[i] - va[i];
      wdata.s[i]  = EW'(origin[i]) - va[i];
    end
    wdata.feature = in_data[9*CW +: CW];
    wdata.ok      = in_ok;
    wdata.last    = in_last;
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

// File: rtl/rtc_queue.sv
// Two-entry queue between the front end and the intersection engine.
// Depends on rtc_pkg.
module rtc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rtc_pkg::tri_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output rtc_pkg::tri_t rdata
);

  rtc_pkg::tri_t mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign rdata = mem[rp];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !valid |-> !pop) else $error("queue read while empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> valid) else $error("queue lost an item");

endmodule

// File: rtl/rtc_back.sv
// Intersection engine: shared digit multiplier sequenced over the test,
// bit-per-cycle divider for the distance, closest-hit tracking. Uses rtc_pkg.
module rtc_back #(
  parameter int FRAC_BITS    = rtc_pkg::FRAC_BITS_DEF,
  parameter int PARALLEL_EPS = rtc_pkg::PARALLEL_EPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  rtc_pkg::tri_t                      q_data,
  output logic                               q_pop,
  input  logic signed [rtc_pkg::DW-1:0]      dir [3],
  input  logic [rtc_pkg::OUT_W-1:0]          max_distance,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [rtc_pkg::OUT_W-1:0]          out_feature,
  output logic [rtc_pkg::OUT_W-1:0]          out_dist
);

  localparam int EW    = rtc_pkg::EW;
  localparam int HW    = rtc_pkg::HW;
  localparam int QW    = rtc_pkg::QW;
  localparam int PW    = rtc_pkg::PW;
  localparam int TW    = rtc_pkg::TW;
  localparam int AW    = rtc_pkg::AW;
  localparam int BW    = rtc_pkg::BW;
  localparam int DIG   = rtc_pkg::DIG;
  localparam int PRODW = rtc_pkg::PRODW;
  localparam int ACCW  = rtc_pkg::ACCW;
  localparam int OW    = rtc_pkg::OUT_W;
  localparam int RW    = rtc_pkg::RW;
  localparam int UW    = rtc_pkg::UPC_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SEQ   = 7'b0000010,
    ST_NEG   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_DIVI  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_UPD   = 7'b1000000
  } state_t;

  state_t state;
  logic [UW-1:0] upc;
  logic [1:0]    phase;
  logic [1:0]    pk;

  logic signed [EW-1:0]    e1 [3];
  logic signed [EW-1:0]    e2 [3];
  logic signed [EW-1:0]    sv [3];
  logic [OW-1:0]           feat;
  logic                    ok;
  logic                    last;
  logic signed [HW-1:0]    h [3];
  logic signed [QW-1:0]    q [3];
  logic signed [PW-1:0]    det;
  logic signed [PW-1:0]    un;
  logic signed [PW-1:0]    vn;
  logic signed [TW-1:0]    tn;
  logic signed [PRODW-1:0] preg;
  logic signed [ACCW-1:0]  acc;

  logic [RW-1:0] rem;
  logic [OW-1:0] nsh;
  logic [OW-1:0] quo;
  logic [4:0]    cnt;
  logic [OW-1:0] tri_dist;
  logic          tri_hit;

  logic [OW-1:0] best_dist;
  logic [OW-1:0] best_feature;
  logic          found;

  rtc_pkg::op_t            op;
  logic signed [AW-1:0]    a_op;
  logic signed [BW-1:0]    b_op;
  logic signed [DIG:0]     dig;
  logic signed [PRODW-1:0] prod;
  logic signed [ACCW-1:0]  ext;
  logic signed [ACCW-1:0]  term;
  logic signed [ACCW-1:0]  base;
  logic signed [ACCW-1:0]  acc_next;

  assign op = rtc_pkg::uop(upc);

  always_comb begin
    case (op.asel)
      rtc_pkg::A_E2: a_op = AW'(e2[op.aidx]);
      rtc_pkg::A_S:  a_op = AW'(sv[op.aidx]);
      rtc_pkg::A_H:  a_op = AW'(h[op.aidx]);
      default:       a_op = AW'(q[op.aidx]);
    endcase
    case (op.bsel)
      rtc_pkg::B_D:  b_op = BW'(dir[op.bidx]);
      rtc_pkg::B_E1: b_op = BW'(e1[op.bidx]);
      rtc_pkg::B_S:  b_op = BW'(sv[op.bidx]);
      default:       b_op = BW'(e2[op.bidx]);
    endcase
    // low digits are unsigned, the top digit carries the sign
    case (phase)
      2'd0:    dig = {1'b0, b_op[DIG-1:0]};
      2'd1:    dig = {1'b0, b_op[2*DIG-1:DIG]};
      default: dig = {b_op[BW-1], b_op[BW-1 -: DIG]};
    endcase
  end

  assign prod = a_op * dig;
  assign ext  = ACCW'(preg);

  always_comb begin
    case (pk)
      2'd0:    term = ext;
      2'd1:    term = ext <<< DIG;
      default: term = ext <<< (2 * DIG);
    endcase
    base     = (phase == 2'd1 && op.first) ? '0 : acc;
    acc_next = op.neg ? (base - term) : (base + term);
  end

  // hit test on the sign-corrected values
  logic signed [PW:0] uv_sum;
  logic               hit_ok;
  logic [TW-1:0]      r0;
  logic [TW-1:0]      tsh;
  logic [RW-1:0]      r2;
  logic               qbit;
  logic [OW-1:0]      quo_next;

  always_comb begin
    uv_sum = {un[PW-1], un} + {vn[PW-1], vn};
    hit_ok = (det != '0) && ($unsigned(det) >= PW'(PARALLEL_EPS)) &&
             !un[PW-1] && (un <= det) && !vn[PW-1] &&
             (uv_sum <= $signed({1'b0, det})) && !tn[TW-1] && (tn != '0);
    r0       = $unsigned(tn) >> (OW - FRAC_BITS);
    tsh      = $unsigned(tn) << FRAC_BITS;
    r2       = {rem[RW-2:0], nsh[OW-1]};
    qbit     = (r2 >= {1'b0, $unsigned(det)});
    quo_next = {quo[OW-2:0], qbit};
  end

  logic          take;
  logic [OW-1:0] nb_dist;
  logic [OW-1:0] nb_feat;
  logic          nb_found;
  logic          emit;

  always_comb begin
    take     = tri_hit && ok && (tri_dist < max_distance) && (tri_dist < best_dist);
    nb_dist  = take ? tri_dist : best_dist;
    nb_feat  = take ? feat : best_feature;
    nb_found = found || take;
  end

  assign emit  = (state == ST_UPD) && last && (!out_valid || out_ready);
  assign q_pop = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      upc          <= '0;
      phase        <= 2'd0;
      out_valid    <= 1'b0;
      best_dist    <= '1;
      best_feature <= '0;
      found        <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < 3; i++) begin
              e1[i] <= $signed(q_data.e1[i]);
              e2[i] <= $signed(q_data.e2[i]);
              sv[i] <= $signed(q_data.s[i]);
            end
            feat  <= q_data.feature;
            ok    <= q_data.ok;
            last  <= q_data.last;
            upc   <= '0;
            phase <= 2'd0;
            state <= ST_SEQ;
          end
        end
        ST_SEQ: begin
          if (phase != 2'd3) begin
            preg <= prod;
            pk   <= phase;
          end
          if (phase != 2'd0) acc <= acc_next;
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            case (op.dst)
              rtc_pkg::DST_H:   h[op.didx] <= acc_next[HW-1:0];
              rtc_pkg::DST_Q:   q[op.didx] <= acc_next[QW-1:0];
              rtc_pkg::DST_DET: det <= acc_next[PW-1:0];
              rtc_pkg::DST_UN:  un  <= acc_next[PW-1:0];
              rtc_pkg::DST_VN:  vn  <= acc_next[PW-1:0];
              rtc_pkg::DST_TN:  tn  <= acc_next[TW-1:0];
              default: ;
            endcase
            if (upc == UW'(rtc_pkg::NUM_OPS - 1)) state <= ST_NEG;
            else upc <= upc + 1'b1;
          end
        end
        ST_NEG: begin
          if (det[PW-1]) begin
            det <= -det;
            un  <= -un;
            vn  <= -vn;
            tn  <= -tn;
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          tri_hit <= 1'b0;
          state   <= hit_ok ? ST_DIVI : ST_UPD;
        end
        ST_DIVI: begin
          if (r0 >= TW'($unsigned(det))) begin
            tri_dist <= '1;
            tri_hit  <= 1'b1;
            state    <= ST_UPD;
          end else begin
            rem   <= r0[RW-1:0];
            nsh   <= tsh[OW-1:0];
            quo   <= '0;
            cnt   <= 5'(OW - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (qbit) rem <= r2 - {1'b0, $unsigned(det)};
          else rem <= r2;
          nsh <= {nsh[OW-2:0], 1'b0};
          quo <= quo_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            tri_dist <= quo_next;
            tri_hit  <= 1'b1;
            state    <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (!last) begin
            best_dist    <= nb_dist;
            best_feature <= nb_feat;
            found        <= nb_found;
            state        <= ST_IDLE;
          end else if (emit) begin
            out_hit      <= nb_found;
            out_feature  <= nb_found ? nb_feat : '0;
            out_dist     <= nb_found ? nb_dist : '1;
            best_dist    <= '1;
            best_feature <= '0;
            found        <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_det: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < {1'b0, $unsigned(det)}))
    else $error("divider remainder not below divisor");
  a_det_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> !det[PW-1]) else $error("det negative after correction");
  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEQ) |-> (upc < UW'(rtc_pkg::NUM_OPS)))
    else $error("micro-op counter out of range");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_dist)))
    else $error("pending result changed");

endmodule

// File: rtl/ray_triangle_closest_hit.sv
// Closest-hit ray/triangle test over a stream of triangles.
// Top level: configuration registers, front end, queue and engine. Uses rtc_pkg.
//
// Usage: write the ray (origin, unit direction, max distance) on the cfg
// channel while the block is idle, then stream triangles on s_axis. Each item
// holds the three vertices and a feature id in tdata, the feature-valid bit in
// tuser and the end-of-query mark in tlast. Only the item with tlast produces
// a result on m_axis: feature id and distance in tdata, the hit flag in tuser.
// The triangle rate is set by the single 68x12 digit multiplier, stepped
// through 24 products, and by the one-bit-per-cycle distance divider; a
// triangle rejected by the bounds test, or whose distance saturates, skips
// the divider. The engine pops the next triangle only when done with the last.
// The front end forms the edges in the accept cycle and a two-entry queue
// lets it take up to two triangles ahead of the engine.
// Reset (synchronous, rst high) clears the queue, the best-hit state and the
// ray registers to origin 0, direction +x, max distance all ones.
// When m_axis stalls, the result stays in its register; the engine finishes
// the next query up to its last triangle and then holds until it drains.
module ray_triangle_closest_hit #(
  parameter int FRAC_BITS    = rtc_pkg::FRAC_BITS_DEF,
  parameter int PARALLEL_EPS = rtc_pkg::PARALLEL_EPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_feature
  input  logic [rtc_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
  // feature_ok
  input  logic [0:0]                          s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit_feature, hit_distance
  output logic [rtc_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
  // hit
  output logic [0:0]                          m_axis_tuser
);

  localparam int CW = rtc_pkg::CW;
  localparam int DW = rtc_pkg::DW;
  localparam int OW = rtc_pkg::OUT_W;

  logic signed [CW-1:0] origin [3];
  logic signed [DW-1:0] dir [3];
  logic [OW-1:0]        max_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]    <= '0;
      origin[1]    <= '0;
      origin[2]    <= '0;
      dir[0]       <= DW'(65536);
      dir[1]       <= '0;
      dir[2]       <= '0;
      max_distance <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtc_pkg::CFG_ORIGIN_X: origin[0]    <= cfg_data;
        rtc_pkg::CFG_ORIGIN_Y: origin[1]    <= cfg_data;
        rtc_pkg::CFG_ORIGIN_Z: origin[2]    <= cfg_data;
        rtc_pkg::CFG_DIR_X:    dir[0]       <= cfg_data[DW-1:0];
        rtc_pkg::CFG_DIR_Y:    dir[1]       <= cfg_data[DW-1:0];
        rtc_pkg::CFG_DIR_Z:    dir[2]       <= cfg_data[DW-1:0];
        rtc_pkg::CFG_MAX_DIST: max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  rtc_pkg::tri_t wdata;
  rtc_pkg::tri_t rdata;
  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          out_hit;
  logic [OW-1:0] out_feature;
  logic [OW-1:0] out_dist;

  rtc_front u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_ok    (s_axis_tuser[0]),
    .in_last  (s_axis_tlast),
    .origin   (origin),
    .q_full   (q_full),
    .push     (push),
    .wdata    (wdata)
  );

  rtc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (rdata)
  );

  rtc_back #(
    .FRAC_BITS    (FRAC_BITS),
    .PARALLEL_EPS (PARALLEL_EPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (rdata),
    .q_pop        (q_pop),
    .dir          (dir),
    .max_distance (max_distance),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_hit      (out_hit),
    .out_feature  (out_feature),
    .out_dist     (out_dist)
  );

  assign m_axis_tdata = {out_dist, out_feature};
  assign m_axis_tuser = out_hit;

endmodule
